### src/egcd_pkg.sv
package egcd_pkg;

  localparam int unsigned OPERAND_BITS = 31;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ALIGN,
    ST_REDUCE,
    ST_FINISH
  } state_t;

endpackage

### src/extended_gcd_mod_inverse_top.sv
// for b = 0 the sequencer goes from idle straight to finish, skipping the euclid steps;
// a finished result waits in finish while the previous result still waits on m_tready
// a fit compare gates each subtract: the divisor is shifted up one bit a cycle, then walked
// back down producing one quotient bit a cycle while the bezout pair is updated alongside
// throughput: one item at a time, the next is accepted when the sequencer returns to idle
// reset: synchronous active-high rst clears the sequencer and the output valid
module extended_gcd_mod_inverse_top #(
  parameter int unsigned OPERAND_BITS = egcd_pkg::OPERAND_BITS
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       s_tvalid,
  output logic                                       s_tready,
  // a_value, b_value
  input  logic [((2 * OPERAND_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  output logic                                       m_tvalid,
  input  logic                                       m_tready,
  // gcd_value, coef_a, coef_b, inverse, inverse_valid
  output logic [((4 * OPERAND_BITS + 3 + 7) / 8) * 8 - 1:0] m_tdata
);

  localparam int unsigned N     = OPERAND_BITS;
  localparam int unsigned CW    = N + 2;
  localparam int unsigned KW    = $clog2(N);
  localparam int unsigned OUT_W = ((4 * N + 3 + 7) / 8) * 8;
  localparam int unsigned PAD_W = OUT_W - (4 * N + 3);

  egcd_pkg::state_t state, state_next;

  logic [N-1:0]          rem, rem_next;
  logic [N-1:0]          r1, r1_next;
  logic [N-1:0]          d, d_next;
  logic [N-1:0]          modulus, modulus_next;
  logic signed [CW-1:0]  s0, s0_next, s1, s1_next, cs, cs_next;
  logic signed [CW-1:0]  t0, t0_next, t1, t1_next, ct, ct_next;
  logic [KW-1:0]         k, k_next;

  logic                  out_valid, out_valid_next;
  logic [N-1:0]          gcd_out, gcd_out_next;
  logic [N:0]            coef_a_out, coef_a_out_next;
  logic [N:0]            coef_b_out, coef_b_out_next;
  logic [N-1:0]          inv_out, inv_out_next;
  logic                  inv_ok_out, inv_ok_out_next;

  logic [N-1:0]          a_in, b_in;
  logic                  fit;
  logic [N-1:0]          rem_sub;
  logic signed [CW-1:0]  s_sub, t_sub, x_plus, inv_full;
  logic                  inv_ok;

  assign a_in = s_tdata[N-1:0];
  assign b_in = s_tdata[2*N-1:N];

  assign fit     = (d <= rem);
  assign rem_sub = fit ? (rem - d) : rem;
  assign s_sub   = fit ? (s0 - cs) : s0;
  assign t_sub   = fit ? (t0 - ct) : t0;

  assign inv_ok   = (rem == {{(N-1){1'b0}}, 1'b1}) && (modulus != '0);
  assign x_plus   = s0 + $signed({2'b00, modulus});
  assign inv_full = s0[CW-1] ? x_plus : s0;

  assign s_tready = (state == egcd_pkg::ST_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = {{PAD_W{1'b0}}, inv_ok_out, inv_out, coef_b_out, coef_a_out, gcd_out};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= egcd_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
    rem        <= rem_next;
    r1         <= r1_next;
    d          <= d_next;
    modulus    <= modulus_next;
    s0         <= s0_next;
    s1         <= s1_next;
    cs         <= cs_next;
    t0         <= t0_next;
    t1         <= t1_next;
    ct         <= ct_next;
    k          <= k_next;
    gcd_out    <= gcd_out_next;
    coef_a_out <= coef_a_out_next;
    coef_b_out <= coef_b_out_next;
    inv_out    <= inv_out_next;
    inv_ok_out <= inv_ok_out_next;
  end

  always_comb begin
    state_next      = state;
    rem_next        = rem;
    r1_next         = r1;
    d_next          = d;
    modulus_next    = modulus;
    s0_next         = s0;
    s1_next         = s1;
    cs_next         = cs;
    t0_next         = t0;
    t1_next         = t1;
    ct_next         = ct;
    k_next          = k;
    out_valid_next  = out_valid && !m_tready;
    gcd_out_next    = gcd_out;
    coef_a_out_next = coef_a_out;
    coef_b_out_next = coef_b_out;
    inv_out_next    = inv_out;
    inv_ok_out_next = inv_ok_out;

    case (state)
      egcd_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          rem_next     = a_in;
          r1_next      = b_in;
          d_next       = b_in;
          modulus_next = b_in;
          s0_next      = CW'(1);
          s1_next      = '0;
          cs_next      = '0;
          t0_next      = '0;
          t1_next      = CW'(1);
          ct_next      = CW'(1);
          k_next       = '0;
          state_next   = (b_in == '0) ? egcd_pkg::ST_FINISH : egcd_pkg::ST_ALIGN;
        end
      end
      egcd_pkg::ST_ALIGN: begin
        // shift the divisor up while twice it still fits
        if (d <= (rem >> 1)) begin
          d_next  = d << 1;
          cs_next = cs <<< 1;
          ct_next = ct <<< 1;
          k_next  = k + KW'(1);
        end else begin
          state_next = egcd_pkg::ST_REDUCE;
        end
      end
      egcd_pkg::ST_REDUCE: begin
        if (k == '0) begin
          // step done: rotate remainder and bezout pairs
          rem_next   = r1;
          r1_next    = rem_sub;
          d_next     = rem_sub;
          s0_next    = s1;
          s1_next    = s_sub;
          cs_next    = s_sub;
          t0_next    = t1;
          t1_next    = t_sub;
          ct_next    = t_sub;
          state_next = (rem_sub == '0) ? egcd_pkg::ST_FINISH : egcd_pkg::ST_ALIGN;
        end else begin
          rem_next = rem_sub;
          s0_next  = s_sub;
          t0_next  = t_sub;
          d_next   = d >> 1;
          cs_next  = cs >>> 1;
          ct_next  = ct >>> 1;
          k_next   = k - KW'(1);
        end
      end
      egcd_pkg::ST_FINISH: begin
        if (!out_valid || m_tready) begin
          out_valid_next  = 1'b1;
          gcd_out_next    = rem;
          coef_a_out_next = s0[N:0];
          coef_b_out_next = t0[N:0];
          inv_out_next    = inv_ok ? inv_full[N-1:0] : '0;
          inv_ok_out_next = inv_ok;
          state_next      = egcd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = egcd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
